// ----- design/sie_pkg.sv -----
// Shared types and constants for the shader instruction encoder.
// Holds function codes, opcodes, the controller state type and the decoded operand struct.
// No dependencies.
package sie_pkg;

  localparam int unsigned DESC_W = 22;

  localparam logic [3:0] FN_EMPTY = 4'd0;
  localparam logic [3:0] FN_MOV   = 4'd1;
  localparam logic [3:0] FN_DP4   = 4'd2;
  localparam logic [3:0] FN_MUL   = 4'd3;
  localparam logic [3:0] FN_RSQ   = 4'd4;
  localparam logic [3:0] FN_RCP   = 4'd5;
  localparam logic [3:0] FN_NOP   = 4'd6;
  localparam logic [3:0] FN_END   = 4'd7;
  localparam logic [3:0] FN_EX2   = 4'd8;
  localparam logic [3:0] FN_LG2   = 4'd9;

  localparam logic [5:0] OP_MOV = 6'h13;
  localparam logic [5:0] OP_DP4 = 6'h02;
  localparam logic [5:0] OP_MUL = 6'h08;
  localparam logic [5:0] OP_RSQ = 6'h0F;
  localparam logic [5:0] OP_RCP = 6'h0E;
  localparam logic [5:0] OP_EX2 = 6'h05;
  localparam logic [5:0] OP_LG2 = 6'h06;
  localparam logic [5:0] OP_NOP = 6'h21;
  localparam logic [5:0] OP_END = 6'h22;

  localparam logic [8:0] IDENTITY_SEL = 9'b000110110;
  localparam logic [3:0] FULL_MASK    = 4'hF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DESC_W-1:0] desc;
    logic [6:0]        s1_reg;
  } dec_t;

endpackage

// ----- design/shader_instruction_encoder_unit.sv -----
// An accepted item goes from idle to search, which reads the stored descriptors one per cycle
// up to the first hit. A miss over all of them appends the descriptor, or flags a full table.
// The done state then loads the result register; a new item is taken only back in idle.
// An empty item skips the search and goes straight to the done state.
// A stalled result holds the block until it can load. Reset (synchronous, active low) empties
// the table and the result register; table contents are not cleared.
module shader_instruction_encoder_unit #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_func,
  input  logic        in_src1_is_matrix,
  input  logic [15:0] in_src1_swizzle,
  input  logic [15:0] in_src2_swizzle,
  input  logic [15:0] in_dst_swizzle,
  input  logic [4:0]  in_dst_reg,
  input  logic [6:0]  in_src1_reg,
  input  logic [4:0]  in_src2_reg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic        out_word_valid,
  output logic [6:0]  out_desc_index,
  output logic        out_desc_added,
  output logic [21:0] out_desc_word,
  output logic        out_table_full
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  sie_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]   cmp_addr_r, cmp_addr_nxt;
  logic            pend_r, pend_nxt;
  logic [3:0]      func_r, func_nxt;
  sie_pkg::dec_t   dec_r, dec_nxt;
  logic [4:0]      dreg_r, dreg_nxt;
  logic [4:0]      s2reg_r, s2reg_nxt;
  logic [6:0]      idx_r, idx_nxt;
  logic            added_r, added_nxt;
  logic            full_r, full_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_word_r;
  logic            out_word_valid_r;
  logic [6:0]      out_idx_r;
  logic            out_added_r;
  logic [21:0]     out_desc_r;
  logic            out_full_r;

  sie_pkg::dec_t   dec_in;
  logic            mem_we;
  logic            mem_re;
  logic [21:0]     mem_rd_data;
  logic            accept;
  logic            issue;
  logic            hit;
  logic            out_load;
  logic [31:0]     word;
  logic            word_valid;
  logic [5:0]      opcode;
  logic [4:0]      s2_field;

  sie_decode u_decode (
    .is_matrix    (in_src1_is_matrix),
    .src1_swizzle (in_src1_swizzle),
    .src2_swizzle (in_src2_swizzle),
    .dst_swizzle  (in_dst_swizzle),
    .src1_reg     (in_src1_reg),
    .dec          (dec_in)
  );

  sie_desc_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_desc_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (dec_r.desc),
    .rd_en   (mem_re),
    .rd_addr (rd_addr_r[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != sie_pkg::ST_IDLE);
  assign issue    = (rd_addr_r < count_r);
  assign hit      = pend_r && (mem_rd_data == dec_r.desc);

  always_comb begin
    opcode     = '0;
    s2_field   = '0;
    word_valid = 1'b1;
    word       = '0;
    unique case (func_r)
      sie_pkg::FN_MOV: opcode = sie_pkg::OP_MOV;
      sie_pkg::FN_DP4: begin
        opcode   = sie_pkg::OP_DP4;
        s2_field = s2reg_r;
      end
      sie_pkg::FN_MUL: begin
        opcode   = sie_pkg::OP_MUL;
        s2_field = s2reg_r;
      end
      sie_pkg::FN_RSQ: opcode = sie_pkg::OP_RSQ;
      sie_pkg::FN_RCP: opcode = sie_pkg::OP_RCP;
      sie_pkg::FN_EX2: opcode = sie_pkg::OP_EX2;
      sie_pkg::FN_LG2: opcode = sie_pkg::OP_LG2;
      sie_pkg::FN_NOP: opcode = sie_pkg::OP_NOP;
      sie_pkg::FN_END: opcode = sie_pkg::OP_END;
      default:         word_valid = 1'b0;
    endcase
    if (func_r == sie_pkg::FN_NOP || func_r == sie_pkg::FN_END) begin
      word = {opcode, 26'd0};
    end else if (word_valid) begin
      word = {opcode, dreg_r, 2'b00, dec_r.s1_reg, s2_field, idx_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_addr_nxt   = rd_addr_r;
    cmp_addr_nxt  = cmp_addr_r;
    pend_nxt      = 1'b0;
    func_nxt      = func_r;
    dec_nxt       = dec_r;
    dreg_nxt      = dreg_r;
    s2reg_nxt     = s2reg_r;
    idx_nxt       = idx_r;
    added_nxt     = added_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      sie_pkg::ST_IDLE: begin
        if (accept) begin
          func_nxt    = in_func;
          dec_nxt     = dec_in;
          dreg_nxt    = in_dst_reg;
          s2reg_nxt   = in_src2_reg;
          idx_nxt     = '0;
          added_nxt   = 1'b0;
          full_nxt    = 1'b0;
          rd_addr_nxt = '0;
          state_nxt   = (in_func == sie_pkg::FN_EMPTY) ? sie_pkg::ST_DONE
                                                       : sie_pkg::ST_SEARCH;
        end
      end
      sie_pkg::ST_SEARCH: begin
        mem_re       = issue;
        pend_nxt     = issue;
        cmp_addr_nxt = rd_addr_r;
        if (issue) begin
          rd_addr_nxt = rd_addr_r + CW'(1);
        end
        if (hit) begin
          idx_nxt   = 7'(cmp_addr_r);
          pend_nxt  = 1'b0;
          state_nxt = sie_pkg::ST_DONE;
        end else if (!issue) begin
          if (count_r < DEPTH_C) begin
            mem_we    = 1'b1;
            idx_nxt   = 7'(count_r);
            count_nxt = count_r + CW'(1);
            added_nxt = 1'b1;
          end else begin
            full_nxt = 1'b1;
            idx_nxt  = '0;
          end
          state_nxt = sie_pkg::ST_DONE;
        end
      end
      sie_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sie_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sie_pkg::ST_IDLE;
      count_r     <= '0;
      rd_addr_r   <= '0;
      cmp_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_addr_r   <= rd_addr_nxt;
      cmp_addr_r  <= cmp_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    dec_r   <= dec_nxt;
    dreg_r  <= dreg_nxt;
    s2reg_r <= s2reg_nxt;
    idx_r   <= idx_nxt;
    added_r <= added_nxt;
    full_r  <= full_nxt;
    if (out_load) begin
      if (func_r == sie_pkg::FN_EMPTY) begin
        out_word_r       <= '0;
        out_word_valid_r <= 1'b0;
        out_idx_r        <= '0;
        out_added_r      <= 1'b0;
        out_desc_r       <= '0;
        out_full_r       <= 1'b0;
      end else begin
        out_word_r       <= word;
        out_word_valid_r <= word_valid;
        out_idx_r        <= idx_r;
        out_added_r      <= added_r;
        out_desc_r       <= dec_r.desc;
        out_full_r       <= full_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_word_valid = out_word_valid_r;
  assign out_desc_index = out_idx_r;
  assign out_desc_added = out_added_r;
  assign out_desc_word  = out_desc_r;
  assign out_table_full = out_full_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("Descriptor count exceeds the table depth.");

  a_search_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sie_pkg::ST_SEARCH |-> rd_addr_r <= count_r)
    else $error("Search read address ran past the stored descriptors.");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sie_pkg::ST_DONE))
    else $error("Result register loaded outside the done state.");

  a_added_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_added_r && out_full_r))
    else $error("An item reports both an append and a full table.");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> count_r == $past(count_r) + CW'(1))
    else $error("Append did not advance the descriptor count.");
`endif

endmodule

// ----- design/sie_desc_ram.sv -----
// Operand descriptor table memory with one write port and one registered read port.
// Depends on sie_pkg for the descriptor width.
module sie_desc_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [sie_pkg::DESC_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [sie_pkg::DESC_W-1:0] rd_data
);

  logic [sie_pkg::DESC_W-1:0] mem [DEPTH];
  logic [sie_pkg::DESC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/sie_decode.sv -----
// Swizzle decoder that builds the operand descriptor and the effective source 1 register.
// Depends on sie_pkg for constants and the decoded operand struct.
module sie_decode (
  input  logic          is_matrix,
  input  logic [15:0]   src1_swizzle,
  input  logic [15:0]   src2_swizzle,
  input  logic [15:0]   dst_swizzle,
  input  logic [6:0]    src1_reg,
  output sie_pkg::dec_t dec
);

  function automatic logic [8:0] source_select(input logic [15:0] swz);
    logic [8:0] sel;
    logic [3:0] nib;
    logic [1:0] comp;
    sel = '0;
    if (swz == 16'd0) begin
      sel = sie_pkg::IDENTITY_SEL;
    end else begin
      for (int lane = 0; lane < 4; lane++) begin
        nib  = swz[lane*4 +: 4];
        comp = 2'(nib - 4'd1);
        if (nib >= 4'd1 && nib <= 4'd4) begin
          sel[7-lane*2 +: 2] = sel[7-lane*2 +: 2] | comp;
        end
      end
    end
    return sel;
  endfunction

  function automatic logic [3:0] dest_mask(input logic [15:0] swz);
    logic [3:0] mask;
    logic [3:0] nib;
    mask = '0;
    if (swz == 16'd0) begin
      mask = sie_pkg::FULL_MASK;
    end else begin
      for (int lane = 0; lane < 4; lane++) begin
        nib = swz[lane*4 +: 4];
        if (nib >= 4'd1 && nib <= 4'd4) begin
          mask[2'(4'd4 - nib)] = 1'b1;
        end
      end
    end
    return mask;
  endfunction

  logic [8:0] sel1;
  logic [8:0] sel2;

  assign sel1 = is_matrix ? sie_pkg::IDENTITY_SEL : source_select(src1_swizzle);
  assign sel2 = source_select(src2_swizzle);

  assign dec.desc   = {sel2, sel1, dest_mask(dst_swizzle)};
  assign dec.s1_reg = src1_reg + (is_matrix ? src1_swizzle[6:0] : 7'd0);

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for shader_instruction_encoder_unit.
// Predicts each encoded word and the descriptor table state in step with accepted items.
// Depends on sie_pkg and the encoder RTL.
module tb_top;

  localparam int STORE_DEPTH = 128;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [3:0] FN_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] FN_UNKNOWN_HI = 4'd15;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  typedef struct packed {
    logic [3:0]  func;
    logic        src1_is_matrix;
    logic [15:0] src1_swizzle;
    logic [15:0] src2_swizzle;
    logic [15:0] dst_swizzle;
    logic [4:0]  dst_reg;
    logic [6:0]  src1_reg;
    logic [4:0]  src2_reg;
  } instr_t;

  typedef struct packed {
    logic [31:0] word;
    logic        word_valid;
    logic [6:0]  desc_index;
    logic        desc_added;
    logic [21:0] desc_word;
    logic        table_full;
  } encoding_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_func = '0;
  logic        in_src1_is_matrix = 1'b0;
  logic [15:0] in_src1_swizzle = '0;
  logic [15:0] in_src2_swizzle = '0;
  logic [15:0] in_dst_swizzle = '0;
  logic [4:0]  in_dst_reg = '0;
  logic [6:0]  in_src1_reg = '0;
  logic [4:0]  in_src2_reg = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_word;
  logic        out_word_valid;
  logic [6:0]  out_desc_index;
  logic        out_desc_added;
  logic [21:0] out_desc_word;
  logic        out_table_full;

  logic [21:0] desc_store [STORE_DEPTH];
  int          desc_fill = 0;
  encoding_t   queued_encodings [$];
  instr_t      issued_ops [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  logic        hold_off_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          phase_left = 0;
  rx_mode_t    rx_mode = RX_FLOW;

  shader_instruction_encoder_unit #(.TABLE_DEPTH(STORE_DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_src1_is_matrix(in_src1_is_matrix),
    .in_src1_swizzle  (in_src1_swizzle),
    .in_src2_swizzle  (in_src2_swizzle),
    .in_dst_swizzle   (in_dst_swizzle),
    .in_dst_reg       (in_dst_reg),
    .in_src1_reg      (in_src1_reg),
    .in_src2_reg      (in_src2_reg),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word         (out_word),
    .out_word_valid   (out_word_valid),
    .out_desc_index   (out_desc_index),
    .out_desc_added   (out_desc_added),
    .out_desc_word    (out_desc_word),
    .out_table_full   (out_table_full)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [8:0] swizzle_select(logic [15:0] swz);
    int unsigned sel;
    int unsigned nib;
    sel = 0;
    if (swz == 16'h0) return sie_pkg::IDENTITY_SEL;
    for (int lane = 0; lane < 4; lane++) begin
      nib = swz[lane*4 +: 4];
      if (nib >= 1 && nib <= 4) sel |= (nib - 1) << (7 - 2 * lane);
    end
    return 9'(sel);
  endfunction

  function automatic logic [3:0] write_mask(logic [15:0] swz);
    int unsigned mask;
    int unsigned nib;
    mask = 0;
    if (swz == 16'h0) return sie_pkg::FULL_MASK;
    for (int lane = 0; lane < 4; lane++) begin
      nib = swz[lane*4 +: 4];
      if (nib >= 1 && nib <= 4) mask |= 1 << (4 - nib);
    end
    return 4'(mask);
  endfunction

  function automatic logic [31:0] assemble_word(logic [5:0] op, logic [6:0] idx,
                                                logic [4:0] dst, logic [6:0] s1,
                                                logic [4:0] s2);
    return {op, dst, 2'b00, s1, s2, idx};
  endfunction

  // Updates the descriptor table exactly as the block does for one accepted item and returns its expected result.
  function automatic encoding_t encode_instr(instr_t it);
    encoding_t   r;
    logic [21:0] desc;
    logic [6:0]  idx;
    logic [6:0]  s1_eff;
    bit          hit;
    r = '0;
    if (it.func == sie_pkg::FN_EMPTY) return r;
    desc = {swizzle_select(it.src2_swizzle),
            it.src1_is_matrix ? sie_pkg::IDENTITY_SEL : swizzle_select(it.src1_swizzle),
            write_mask(it.dst_swizzle)};
    idx = '0;
    hit = 1'b0;
    for (int i = 0; i < desc_fill; i++) begin
      if (!hit && desc_store[i] == desc) begin
        idx = 7'(i);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (desc_fill < STORE_DEPTH) begin
        idx = 7'(desc_fill);
        desc_store[desc_fill] = desc;
        desc_fill++;
        r.desc_added = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    s1_eff = it.src1_reg + (it.src1_is_matrix ? it.src1_swizzle[6:0] : 7'd0);
    r.word_valid = 1'b1;
    case (it.func)
      sie_pkg::FN_MOV:
        r.word = assemble_word(sie_pkg::OP_MOV, idx, it.dst_reg, s1_eff, 5'd0);
      sie_pkg::FN_DP4:
        r.word = assemble_word(sie_pkg::OP_DP4, idx, it.dst_reg, s1_eff, it.src2_reg);
      sie_pkg::FN_MUL:
        r.word = assemble_word(sie_pkg::OP_MUL, idx, it.dst_reg, s1_eff, it.src2_reg);
      sie_pkg::FN_RSQ:
        r.word = assemble_word(sie_pkg::OP_RSQ, idx, it.dst_reg, s1_eff, 5'd0);
      sie_pkg::FN_RCP:
        r.word = assemble_word(sie_pkg::OP_RCP, idx, it.dst_reg, s1_eff, 5'd0);
      sie_pkg::FN_NOP: r.word = {sie_pkg::OP_NOP, 26'd0};
      sie_pkg::FN_END: r.word = {sie_pkg::OP_END, 26'd0};
      sie_pkg::FN_EX2:
        r.word = assemble_word(sie_pkg::OP_EX2, idx, it.dst_reg, s1_eff, 5'd0);
      sie_pkg::FN_LG2:
        r.word = assemble_word(sie_pkg::OP_LG2, idx, it.dst_reg, s1_eff, 5'd0);
      default: begin
        r.word_valid = 1'b0;
        r.word = '0;
      end
    endcase
    r.desc_index = idx;
    r.desc_word = desc;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : track
    encoding_t exp_r;
    instr_t    seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (queued_encodings.size() == 0) begin
          $error("unexpected result item, word %h", out_word);
          mismatches++;
        end else begin
          exp_r = queued_encodings.pop_front();
          check_field("word", exp_r.word, out_word);
          check_field("word_valid", 32'(exp_r.word_valid), 32'(out_word_valid));
          check_field("desc_index", 32'(exp_r.desc_index), 32'(out_desc_index));
          check_field("desc_added", 32'(exp_r.desc_added), 32'(out_desc_added));
          check_field("desc_word", 32'(exp_r.desc_word), 32'(out_desc_word));
          check_field("table_full", 32'(exp_r.table_full), 32'(out_table_full));
        end
      end
      if (in_valid && !in_stall) begin
        seen = {in_func, in_src1_is_matrix, in_src1_swizzle, in_src2_swizzle,
                in_dst_swizzle, in_dst_reg, in_src1_reg, in_src2_reg};
        queued_encodings.insert(queued_encodings.size(), encode_instr(seen));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_off_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(1, 64);
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
      end else begin
        phase_left <= phase_left - 1;
      end
      case (rx_mode)
        RX_FLOW: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= !out_stall;
      endcase
    end
  end

  task automatic send_item(input instr_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= it.func;
    in_src1_is_matrix <= it.src1_is_matrix;
    in_src1_swizzle <= it.src1_swizzle;
    in_src2_swizzle <= it.src2_swizzle;
    in_dst_swizzle <= it.dst_swizzle;
    in_dst_reg <= it.dst_reg;
    in_src1_reg <= it.src1_reg;
    in_src2_reg <= it.src2_reg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic instr_t make_instr(logic [3:0] func, logic mat, logic [15:0] s1,
                                        logic [15:0] s2, logic [15:0] d, logic [4:0] dreg,
                                        logic [6:0] s1reg, logic [4:0] s2reg);
    return {func, mat, s1, s2, d, dreg, s1reg, s2reg};
  endfunction

  function automatic logic [15:0] random_swizzle(bit legal_only);
    logic [15:0] swz;
    swz = '0;
    case (legal_only ? 2 : $urandom_range(0, 4))
      0: swz = 16'h0;
      1: swz = 16'($urandom);
      2, 3: begin
        for (int lane = 0; lane < 4; lane++) swz[lane*4 +: 4] = 4'($urandom_range(0, 4));
      end
      default: swz = 16'($urandom_range(1, 4)) << (4 * $urandom_range(0, 3));
    endcase
    return swz;
  endfunction

  function automatic instr_t random_instr(bit fresh);
    instr_t it;
    if (!fresh && $urandom_range(0, 7) == 0) it.func = 4'($urandom_range(0, 15));
    else it.func = 4'($urandom_range(sie_pkg::FN_MOV, sie_pkg::FN_LG2));
    it.src1_is_matrix = fresh ? 1'b0 : ($urandom_range(0, 4) == 0);
    it.src1_swizzle = random_swizzle(fresh);
    it.src2_swizzle = random_swizzle(fresh);
    it.dst_swizzle = random_swizzle(fresh);
    it.dst_reg = 5'($urandom);
    it.src1_reg = 7'($urandom);
    it.src2_reg = 5'($urandom);
    return it;
  endfunction

  // A reuse_pct share of items reuse the operand swizzles of an earlier item so that lookups hit.
  task automatic send_mixed(input int count, input int reuse_pct);
    instr_t it;
    instr_t prior;
    repeat (count) begin
      it = random_instr(1'b0);
      if (issued_ops.size() > 0 && $urandom_range(0, 99) < reuse_pct) begin
        prior = issued_ops[$urandom_range(0, issued_ops.size() - 1)];
        it.src1_is_matrix = prior.src1_is_matrix;
        if (!prior.src1_is_matrix) it.src1_swizzle = prior.src1_swizzle;
        it.src2_swizzle = prior.src2_swizzle;
        it.dst_swizzle = prior.dst_swizzle;
      end else if (it.func != sie_pkg::FN_EMPTY) begin
        issued_ops.insert(issued_ops.size(), it);
      end
      send_item(it);
    end
  endtask

  task automatic test_directed();
    send_item(make_instr(sie_pkg::FN_EMPTY,
                         1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 7'd127, 5'd31));
    send_item(make_instr(sie_pkg::FN_MOV,
                         1'b0, 16'h0, 16'h0, 16'h0, 5'd0, 7'd0, 5'd0));
    send_item(make_instr(sie_pkg::FN_MOV,
                         1'b0, 16'h0, 16'h0, 16'h0, 5'd31, 7'd127, 5'd31));
    send_item(make_instr(sie_pkg::FN_DP4,
                         1'b0, 16'h1234, 16'h4321, 16'h0001, 5'd31, 7'd127, 5'd31));
    send_item(make_instr(sie_pkg::FN_MUL,
                         1'b0, 16'h4321, 16'h1234, 16'h4321, 5'd1, 7'd2, 5'd3));
    send_item(make_instr(sie_pkg::FN_RSQ,
                         1'b0, 16'h5555, 16'hFFFF, 16'h5678, 5'd7, 7'd64, 5'd16));
    send_item(make_instr(sie_pkg::FN_RCP,
                         1'b0, 16'h0F10, 16'h0500, 16'hA0B0, 5'd16, 7'd1, 5'd8));
    send_item(make_instr(sie_pkg::FN_NOP,
                         1'b0, 16'h3412, 16'h2222, 16'h0002, 5'd9, 7'd33, 5'd4));
    send_item(make_instr(sie_pkg::FN_END,
                         1'b1, 16'hABCD, 16'h1111, 16'h0404, 5'd21, 7'd99, 5'd30));
    send_item(make_instr(sie_pkg::FN_EX2,
                         1'b1, 16'hFFFF, 16'h2222, 16'h0003, 5'd5, 7'd127, 5'd9));
    send_item(make_instr(sie_pkg::FN_LG2,
                         1'b1, 16'h0001, 16'h0, 16'h0, 5'd0, 7'd127, 5'd0));
    send_item(make_instr(FN_UNKNOWN_LO,
                         1'b0, 16'h4444, 16'h3333, 16'h1234, 5'd3, 7'd5, 5'd7));
    send_item(make_instr(FN_UNKNOWN_HI,
                         1'b0, 16'h4444, 16'h3333, 16'h1234, 5'd31, 7'd127, 5'd31));
    send_item(make_instr(sie_pkg::FN_MUL,
                         1'b0, 16'h1234, 16'h4321, 16'h0001, 5'd0, 7'd0, 5'd31));
    send_item(make_instr(sie_pkg::FN_DP4,
                         1'b1, 16'h8000, 16'h3333, 16'h1111, 5'd12, 7'd10, 5'd21));
    send_item(make_instr(sie_pkg::FN_MOV,
                         1'b0, 16'h0004, 16'h0040, 16'h0400, 5'd30, 7'd126, 5'd1));
    send_item(make_instr(sie_pkg::FN_EMPTY,
                         1'b0, 16'h0, 16'h0, 16'h0, 5'd0, 7'd0, 5'd0));
  endtask

  task automatic test_descriptor_reuse();
    send_mixed(280, 60);
  endtask

  task automatic test_backpressure();
    hold_off_go <= 1'b1;
    no_gaps = 1'b1;
    send_mixed(40, 50);
    no_gaps = 1'b0;
  endtask

  task automatic test_table_fill();
    repeat (200) send_item(random_instr(1'b1));
  endtask

  task automatic test_full_table();
    send_mixed(180, 50);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_descriptor_reuse();
    test_backpressure();
    test_table_fill();
    test_full_table();
    in_valid <= 1'b0;
    wait (queued_encodings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && queued_encodings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
